FILE: rtl/psd_pkg.sv
// Package for the packet sync deframer: state, event and register codes,
// reset values and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package psd_pkg;

  // default packet length in bytes
  localparam int unsigned PacketBytesDef = 16;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SIG_MASK      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SIG_VALUE     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SIG_OFFSET    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ALIGN_COUNT   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ATTEMPT_LIMIT = 3'd4;

  // register reset values
  localparam logic [7:0]  SigMaskRst      = 8'd255;
  localparam logic [7:0]  SigValueRst     = 8'd0;
  localparam logic [5:0]  SigOffsetRst    = 6'd15;
  localparam logic [7:0]  AlignCountRst   = 8'd4;
  localparam logic [15:0] AttemptLimitRst = 16'd100;

  // request kinds on the input stream
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_DROP = 1'b1;

  // result event codes
  typedef enum logic [1:0] {
    EV_PKT_BYTE  = 2'd0,
    EV_ALIGNED   = 2'd1,
    EV_MISALIGN  = 2'd2,
    EV_GAVE_UP   = 2'd3
  } event_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_GIVE,
    ST_CHK,
    ST_CHK_EV,
    ST_BRD,
    ST_BOUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic   take;        // latch the accepted byte
    logic   clr_search;  // drop alignment, clear counters, phase, fill
    logic   search_upd;  // update phase counter and phase / attempts
    logic   store_wr;    // write packet byte, advance fill position
    logic   bad_pkt;     // clear search plus attempts and give-up flag
    logic   set_giveup;  // mark give-up as reported
    logic   rd_off;      // store read at signature offset, else burst index
    logic   out_load;    // load the output register
    event_e out_ev;      // event code of the loaded result
    logic   burst_adv;   // step the burst index
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic aligned;
    logic over_limit;
    logic giveup_rep;
    logic hit;
    logic fill_last;
    logic sig_good;
    logic burst_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/psd_ctrl.sv
// Controller state machine of the packet sync deframer.
// Depends on psd_pkg; drives cmd_t to the datapath and reads sts_t back.
`timescale 1ns / 1ps

module psd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_req_i,
  output logic          in_ready_o,
  input  psd_pkg::sts_t sts_i,
  output psd_pkg::cmd_t cmd_o
);
  import psd_pkg::*;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take && in_req_i == REQ_DATA) begin
          if (sts_i.aligned) begin
            if (sts_i.fill_last) state_d = ST_CHK;
          end else if (sts_i.over_limit) begin
            if (!sts_i.giveup_rep) state_d = ST_GIVE;
          end else begin
            state_d = ST_SRCH;
          end
        end
      end
      ST_SRCH, ST_GIVE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_CHK:    state_d = ST_CHK_EV;
      ST_CHK_EV: begin
        if (sts_i.sig_good) begin
          state_d = ST_BRD;
        end else if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_BRD:    state_d = ST_BOUT;
      ST_BOUT: begin
        if (sts_i.out_free) state_d = sts_i.burst_last ? ST_IDLE : ST_BRD;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.out_ev = EV_PKT_BYTE;
    case (state_q)
      ST_IDLE: begin
        cmd_o.take = take;
        if (take) begin
          if (in_req_i == REQ_DROP) begin
            cmd_o.clr_search = 1'b1;
          end else if (sts_i.aligned) begin
            cmd_o.store_wr = 1'b1;
          end else if (sts_i.over_limit && !sts_i.giveup_rep) begin
            cmd_o.set_giveup = 1'b1;
          end
        end
      end
      ST_SRCH: begin
        if (sts_i.out_free) begin
          cmd_o.search_upd = 1'b1;
          cmd_o.out_load   = sts_i.hit;
          cmd_o.out_ev     = EV_ALIGNED;
        end
      end
      ST_GIVE: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_ev   = EV_GAVE_UP;
      end
      ST_CHK: begin
        cmd_o.rd_off = 1'b1;
      end
      ST_CHK_EV: begin
        // keep the signature byte on the read port while the result waits
        cmd_o.rd_off = 1'b1;
        if (!sts_i.sig_good && sts_i.out_free) begin
          cmd_o.bad_pkt  = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_ev   = EV_MISALIGN;
        end
      end
      ST_BRD: begin
        cmd_o.rd_off = 1'b0;
      end
      ST_BOUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_ev    = EV_PKT_BYTE;
          cmd_o.burst_adv = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/psd_dp.sv
// Datapath of the packet sync deframer: configuration registers, phase
// counter memory, packet store, search state and the output register.
// Depends on psd_pkg; driven by psd_ctrl through cmd_t.
`timescale 1ns / 1ps

module psd_dp #(
  parameter int unsigned PACKET_BYTES = psd_pkg::PacketBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [psd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [7:0]                    rx_byte_i,
  input  psd_pkg::cmd_t                 cmd_i,
  output psd_pkg::sts_t                 sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [1:0]                    out_event_o,
  output logic [7:0]                    out_byte_o,
  output logic [5:0]                    out_index_o,
  output logic                          out_last_o
);
  import psd_pkg::*;

  localparam int unsigned IdxW = $clog2(PACKET_BYTES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PACKET_BYTES - 1);

  // configuration registers
  logic [7:0]  sig_mask_q, sig_value_q, align_count_q;
  logic [5:0]  sig_offset_q;
  logic [15:0] attempt_limit_q;

  // search and framing state
  logic            aligned_q, giveup_q;
  logic [15:0]     attempts_q;
  logic [IdxW-1:0] phase_q, fill_q, burst_q;
  logic [7:0]      rx_q;

  // phase counter memory with per-entry valid bits
  logic [7:0]              cnt_mem [PACKET_BYTES];
  logic [PACKET_BYTES-1:0] cnt_vld_q;
  logic [7:0]              cnt_rd_q;
  logic [7:0]              cnt_new;

  // packet store
  logic [7:0]      st_mem [PACKET_BYTES];
  logic [7:0]      st_rd_q;
  logic [IdxW-1:0] st_raddr, off_sat;

  // output register
  logic       out_vld_q, out_last_q;
  logic [1:0] out_ev_q;
  logic [7:0] out_byte_q;
  logic [5:0] out_idx_q;
  logic       out_free;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_mask_q      <= SigMaskRst;
      sig_value_q     <= SigValueRst;
      sig_offset_q    <= SigOffsetRst;
      align_count_q   <= AlignCountRst;
      attempt_limit_q <= AttemptLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SIG_MASK:      sig_mask_q      <= cfg_data_i[7:0];
        REG_SIG_VALUE:     sig_value_q     <= cfg_data_i[7:0];
        REG_SIG_OFFSET:    sig_offset_q    <= cfg_data_i[5:0];
        REG_ALIGN_COUNT:   align_count_q   <= cfg_data_i[7:0];
        REG_ATTEMPT_LIMIT: attempt_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturated signature offset
  assign off_sat = ({1'b0, sig_offset_q} >= 7'(PACKET_BYTES)) ? LastIdx
                                                              : sig_offset_q[IdxW-1:0];
  assign st_raddr = cmd_i.rd_off ? off_sat : burst_q;

  // new counter value for the current phase
  always_comb begin
    if ((rx_q & sig_mask_q) == sig_value_q) begin
      cnt_new = (cnt_rd_q == 8'hFF) ? cnt_rd_q : cnt_rd_q + 8'd1;
    end else begin
      cnt_new = 8'd0;
    end
  end

  assign out_free = !out_vld_q || out_ready_i;

  // status to controller
  always_comb begin
    sts_o.aligned    = aligned_q;
    sts_o.over_limit = attempts_q > attempt_limit_q;
    sts_o.giveup_rep = giveup_q;
    sts_o.hit        = cnt_new >= align_count_q;
    sts_o.fill_last  = fill_q == LastIdx;
    sts_o.sig_good   = (st_rd_q & sig_mask_q) == sig_value_q;
    sts_o.burst_last = burst_q == LastIdx;
    sts_o.out_free   = out_free;
  end

  // control state: alignment, phase, attempts, fill and burst position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aligned_q  <= 1'b0;
      giveup_q   <= 1'b0;
      attempts_q <= '0;
      phase_q    <= '0;
      fill_q     <= '0;
      burst_q    <= '0;
      cnt_vld_q  <= '0;
    end else begin
      if (cmd_i.clr_search || cmd_i.bad_pkt) begin
        aligned_q <= 1'b0;
        phase_q   <= '0;
        fill_q    <= '0;
        cnt_vld_q <= '0;
      end
      if (cmd_i.bad_pkt) begin
        attempts_q <= '0;
        giveup_q   <= 1'b0;
      end
      if (cmd_i.set_giveup) giveup_q <= 1'b1;
      if (cmd_i.search_upd) begin
        cnt_vld_q[phase_q] <= 1'b1;
        if (cnt_new >= align_count_q) begin
          aligned_q <= 1'b1;
          fill_q    <= '0;
        end else if (phase_q == LastIdx) begin
          phase_q <= '0;
          if (attempts_q != 16'hFFFF) attempts_q <= attempts_q + 16'd1;
        end else begin
          phase_q <= phase_q + 1'b1;
        end
      end
      if (cmd_i.store_wr) fill_q <= (fill_q == LastIdx) ? '0 : fill_q + 1'b1;
      if (cmd_i.burst_adv) burst_q <= (burst_q == LastIdx) ? '0 : burst_q + 1'b1;
    end
  end

  // input byte, counter memory and packet store
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) rx_q <= rx_byte_i;
    if (cmd_i.search_upd) cnt_mem[phase_q] <= cnt_new;
    cnt_rd_q <= cnt_vld_q[phase_q] ? cnt_mem[phase_q] : 8'd0;
    if (cmd_i.store_wr) st_mem[fill_q] <= rx_byte_i;
    st_rd_q <= st_mem[st_raddr];
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ev_q <= cmd_i.out_ev;
      if (cmd_i.out_ev == EV_PKT_BYTE) begin
        out_byte_q <= st_rd_q;
        out_idx_q  <= 6'(burst_q);
        out_last_q <= burst_q == LastIdx;
      end else begin
        out_byte_q <= 8'd0;
        out_idx_q  <= 6'd0;
        out_last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_event_o = out_ev_q;
  assign out_byte_o  = out_byte_q;
  assign out_index_o = out_idx_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: rtl/packet_sync_deframer.sv
// Packet sync deframer: finds fixed-length packet framing from a signature
// byte and delivers good packets as byte bursts. Search byte: counter memory read,
// then update. Packet byte in aligned mode: written to the store; the packet end adds
// the check states ST_CHK and ST_CHK_EV, then a store read and an output load per burst byte.
// Output register lets the next request in while a result waits.
// Reset (async, low) clears state and counter valid bits at once; no sweep.
`timescale 1ns / 1ps

module packet_sync_deframer #(
  parameter int unsigned PACKET_BYTES = psd_pkg::PacketBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [psd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [psd_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] rx_byte
  input  logic [0:0]                   s_axis_tuser,  // [0] req_type
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,  // [7:0] out_byte, [13:8] byte_index
  output logic [1:0]                   m_axis_tuser,  // [1:0] event_res
  output logic                         m_axis_tlast   // last
);
  import psd_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [7:0] out_byte;
  logic [5:0] out_index;

  psd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_req_i   (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psd_dp #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .rx_byte_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_event_o (m_axis_tuser),
    .out_byte_o  (out_byte),
    .out_index_o (out_index),
    .out_last_o  (m_axis_tlast)
  );

  // pack output fields, zero filled to whole bytes
  assign m_axis_tdata = {2'b00, out_index, out_byte};

endmodule
